@@ rtl/snpl_pkg.sv @@
// Shared constants and types for the sorted node priority list.
package snpl_pkg;

   // Operation codes carried on the request tuser.
   localparam int FUNC_W = 3;
   localparam logic [FUNC_W-1:0] FUNC_INSERT_SORTED = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADD_FIRST     = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_ADD_END       = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE_FIRST  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_FIND          = 3'd4;

   // Field widths on the ports.
   localparam int VERTEX_W = 10;
   localparam int KEY_W    = 32;
   localparam int COST_W   = 32;
   localparam int POS_W    = 6;
   localparam int COUNT_W  = 7;

   // Request tdata layout.
   localparam int REQ_VERTEX_LSB = 0;
   localparam int REQ_KEY_LSB    = REQ_VERTEX_LSB + VERTEX_W;
   localparam int REQ_PARENT_LSB = REQ_KEY_LSB + KEY_W;
   localparam int REQ_COST_LSB   = REQ_PARENT_LSB + VERTEX_W;
   localparam int REQ_USED_W     = REQ_COST_LSB + COST_W;
   localparam int REQ_DATA_W     = ((REQ_USED_W + 7) / 8) * 8;

   // Response tdata layout.
   localparam int RSP_VERTEX_LSB = 0;
   localparam int RSP_KEY_LSB    = RSP_VERTEX_LSB + VERTEX_W;
   localparam int RSP_PARENT_LSB = RSP_KEY_LSB + KEY_W;
   localparam int RSP_COST_LSB   = RSP_PARENT_LSB + VERTEX_W;
   localparam int RSP_POS_LSB    = RSP_COST_LSB + COST_W;
   localparam int RSP_COUNT_LSB  = RSP_POS_LSB + POS_W;
   localparam int RSP_DROP_LSB   = RSP_COUNT_LSB + COUNT_W;
   localparam int RSP_USED_W     = RSP_DROP_LSB + 1;
   localparam int RSP_DATA_W     = ((RSP_USED_W + 7) / 8) * 8;

   // Per-cell update select, driven from the list control.
   typedef struct packed {
      logic load_new;
      logic take_left;
      logic take_right;
   } cell_ctrl_type;

   // Per-cell compare results, registered inside the cell.
   typedef struct packed {
      logic key_gt;
      logic id_eq;
   } cell_flags_type;

endpackage

@@ rtl/snpl_cell.sv @@
// One slot of the list: holds an entry, compares it and shifts with its neighbors.
module snpl_cell #(
   parameter int ID_BITS = 10,
   localparam int EntryW = 2 * ID_BITS + snpl_pkg::KEY_W + snpl_pkg::COST_W
) (
   input  logic                      clock,
   input  logic                      capture,
   input  logic [EntryW-1:0]         probe_entry,
   input  logic [EntryW-1:0]         new_entry,
   input  logic [EntryW-1:0]         left_entry,
   input  logic [EntryW-1:0]         right_entry,
   input  snpl_pkg::cell_ctrl_type   ctrl,
   output logic [EntryW-1:0]         entry_q,
   output snpl_pkg::cell_flags_type  flags
);
   import snpl_pkg::*;

   logic [EntryW-1:0] entry_ff, entry_in;
   cell_flags_type    flags_ff, flags_in;

   // Compare stored key and id against the incoming request.
   always_comb begin
      flags_in.key_gt = entry_ff[ID_BITS +: KEY_W] > probe_entry[ID_BITS +: KEY_W];
      flags_in.id_eq  = entry_ff[ID_BITS-1:0] == probe_entry[ID_BITS-1:0];
   end

   // Load the new entry, shift from a neighbor, or hold.
   always_comb begin
      if (ctrl.load_new) begin
         entry_in = new_entry;
      end else if (ctrl.take_left) begin
         entry_in = left_entry;
      end else if (ctrl.take_right) begin
         entry_in = right_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (capture) begin
         flags_ff <= flags_in;
      end
   end

   assign entry_q = entry_ff;
   assign flags   = flags_ff;

endmodule

@@ rtl/sorted_node_priority_list.sv @@
// Top level of the sorted node priority list (open list of a path planner).
//
// Usage:
//   One request on req_* carries an operation in req_tuser and an entry in
//   req_tdata: insert sorted, add first, add end, remove first or find.
//   Every request yields exactly one response on rsp_*, with the popped head
//   entry, the found position, the entry count after the operation and a
//   dropped flag for a full list. rsp_tuser is high when a pop returned an
//   entry or a find hit.
//   The list is a row of LEN cells, one entry per cell. On acceptance every
//   cell compares its key and id against the request and registers the
//   result; the control then finds the first hit and, once the output
//   register can take the response, all cells shift, load or hold together.
//   rsp_tvalid rises at the end of the shift cycle. A new request is taken
//   only after the last one has finished its shift cycle, so each request
//   holds the list for its compare cycle and then its shift cycle.
//   When the receiver stalls, a finished response waits in the output
//   register; one more request is taken and held in its shift cycle until
//   the output register frees up.
//   Reset empties the list at once (count to zero) and holds req_tready low;
//   cell contents are not cleared and are never read below the count.
module sorted_node_priority_list #(
   parameter int LEN     = 64,
   parameter int ID_BITS = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   // request: vertex_id, sort_key, parent_id, parent_cost (lowest bit up)
   input  logic [snpl_pkg::REQ_DATA_W-1:0] req_tdata,
   // request: func
   input  logic [snpl_pkg::FUNC_W-1:0]     req_tuser,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // response: out_vertex, out_key, out_parent, out_parent_cost, position,
   //           count, dropped (lowest bit up)
   output logic [snpl_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // response: entry_valid
   output logic                            rsp_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready
);
   import snpl_pkg::*;

   localparam int EntryW = 2 * ID_BITS + KEY_W + COST_W;
   localparam int CountW = $clog2(LEN + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic                  state_ff, state_in;
   logic [CountW-1:0]     count_ff, count_in;
   logic [FUNC_W-1:0]     func_ff;
   logic [EntryW-1:0]     new_entry_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_user_ff, rsp_user_in;

   logic                  req_fire;
   logic                  fire;
   logic [EntryW-1:0]     req_entry;
   logic [ID_BITS+VERTEX_W-1:0] vid_wide, pid_wide;

   logic [EntryW-1:0]     cell_q [LEN];
   cell_flags_type        flags  [LEN];
   cell_ctrl_type         ctrl   [LEN];
   logic [LEN-1:0]        occ, a_vec, a_before, m_vec, m_before;

   logic is_sorted, is_first, is_end, is_insert, is_pop, is_find;
   logic full, nonempty, any_a, any_m, do_insert, do_pop;
   logic [POS_W-1:0]      pos_idx;
   logic [CountW+COUNT_W-1:0]   count_wide;
   logic [ID_BITS+VERTEX_W-1:0] head_vid_wide, head_pid_wide;

   // Build the stored entry from the request; ids are resized to ID_BITS.
   assign vid_wide = {{ID_BITS{1'b0}}, req_tdata[REQ_VERTEX_LSB +: VERTEX_W]};
   assign pid_wide = {{ID_BITS{1'b0}}, req_tdata[REQ_PARENT_LSB +: VERTEX_W]};
   assign req_entry = {req_tdata[REQ_COST_LSB +: COST_W], pid_wide[ID_BITS-1:0],
                       req_tdata[REQ_KEY_LSB +: KEY_W], vid_wide[ID_BITS-1:0]};

   // Take no request while reset holds the control.
   assign req_tready = (state_ff == ST_IDLE) & ~reset;
   assign req_fire   = req_tvalid & req_tready;
   // Finish the shift cycle only when the output register can take the response.
   assign fire       = (state_ff == ST_EXEC) & (~rsp_valid_ff | rsp_tready);

   // Decode the held operation.
   assign is_sorted = (func_ff == FUNC_INSERT_SORTED);
   assign is_first  = (func_ff == FUNC_ADD_FIRST);
   assign is_end    = (func_ff == FUNC_ADD_END);
   assign is_insert = is_sorted | is_first | is_end;
   assign is_pop    = (func_ff == FUNC_REMOVE_FIRST);
   assign is_find   = (func_ff == FUNC_FIND);

   assign full     = (count_ff == CountW'(LEN));
   assign nonempty = (count_ff != '0);
   assign any_a    = |a_vec;
   assign any_m    = |m_vec;

   // An insert with no place (add end, or insert sorted with no greater key, on a full list) is refused.
   assign do_insert = fire & is_insert & any_a;
   assign do_pop    = fire & is_pop & nonempty;

   // Cell row. A cell marks itself as an insert point when its key is greater (insert sorted),
   // when it is empty, or for add first; the first marked cell loads the new entry and every
   // cell after it takes its left neighbor. On a pop every cell takes its right neighbor.
   for (genvar i = 0; i < LEN; i++) begin : g_cell
      logic [EntryW-1:0] left_entry, right_entry;

      if (i == 0) begin : g_head
         assign left_entry  = new_entry_ff;
         assign a_before[i] = 1'b0;
         assign m_before[i] = 1'b0;
      end else begin : g_body
         assign left_entry  = cell_q[i-1];
         assign a_before[i] = |a_vec[i-1:0];
         assign m_before[i] = |m_vec[i-1:0];
      end

      if (i == LEN - 1) begin : g_tail
         assign right_entry = cell_q[i];
      end else begin : g_inner
         assign right_entry = cell_q[i+1];
      end

      assign occ[i]   = (count_ff > CountW'(i));
      assign a_vec[i] = is_first | (is_sorted & flags[i].key_gt) | ~occ[i];
      assign m_vec[i] = flags[i].id_eq & occ[i];

      always_comb begin
         ctrl[i].load_new   = do_insert & a_vec[i] & ~a_before[i];
         ctrl[i].take_left  = do_insert & a_before[i];
         ctrl[i].take_right = do_pop;
      end

      snpl_cell #(
         .ID_BITS (ID_BITS)
      ) u_cell (
         .clock       (clock),
         .capture     (req_fire),
         .probe_entry (req_entry),
         .new_entry   (new_entry_ff),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .ctrl        (ctrl[i]),
         .entry_q     (cell_q[i]),
         .flags       (flags[i])
      );
   end

   // Encode the first matching slot; the index wraps at the port width.
   always_comb begin
      pos_idx = '0;
      for (int i = 0; i < LEN; i++) begin
         if (m_vec[i] & ~m_before[i]) begin
            pos_idx = pos_idx | POS_W'(i);
         end
      end
   end

   // Advance the count.
   always_comb begin
      count_in = count_ff;
      if (do_insert & ~full) begin
         count_in = count_ff + CountW'(1);
      end else if (do_pop) begin
         count_in = count_ff - CountW'(1);
      end
   end

   assign count_wide    = {{COUNT_W{1'b0}}, count_in};
   assign head_vid_wide = {{VERTEX_W{1'b0}}, cell_q[0][ID_BITS-1:0]};
   assign head_pid_wide = {{VERTEX_W{1'b0}}, cell_q[0][ID_BITS+KEY_W +: ID_BITS]};

   // Assemble the response; fields without meaning stay zero.
   always_comb begin
      rsp_data_in = '0;
      rsp_user_in = (is_pop & nonempty) | (is_find & any_m);
      if (is_pop & nonempty) begin
         rsp_data_in[RSP_VERTEX_LSB +: VERTEX_W] = head_vid_wide[VERTEX_W-1:0];
         rsp_data_in[RSP_KEY_LSB +: KEY_W]       = cell_q[0][ID_BITS +: KEY_W];
         rsp_data_in[RSP_PARENT_LSB +: VERTEX_W] = head_pid_wide[VERTEX_W-1:0];
         rsp_data_in[RSP_COST_LSB +: COST_W]     = cell_q[0][2*ID_BITS+KEY_W +: COST_W];
      end
      if (is_find) begin
         rsp_data_in[RSP_POS_LSB +: POS_W] = pos_idx;
      end
      rsp_data_in[RSP_COUNT_LSB +: COUNT_W] = count_wide[COUNT_W-1:0];
      rsp_data_in[RSP_DROP_LSB]             = is_insert & full;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the request and the response payload.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         func_ff      <= req_tuser;
         new_entry_ff <= req_entry;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

@@ verif/sorted_node_priority_list_tb.sv @@
// Self-checking testbench for the sorted node priority list: directed table, then random traffic.
module sorted_node_priority_list_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import snpl_pkg::*;

   localparam int LIST_LEN       = 64;
   localparam int RESET_CYCLES   = 12;
   localparam int DIR_N          = 23;
   localparam int RANDOM_ITEMS   = 450;
   localparam int PHASE_ITEMS    = 90;
   localparam int HOLDOFF_AFTER  = 120;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 10;

   // Codes five to seven select no operation.
   localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = FUNC_FIND + 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = '1;

   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic [VERTEX_W-1:0] vertex;
      logic [KEY_W-1:0]    key;
      logic [VERTEX_W-1:0] parent;
      logic [COST_W-1:0]   cost;
   } node_req_type;

   typedef struct packed {
      logic                entry_valid;
      logic [VERTEX_W-1:0] vertex;
      logic [KEY_W-1:0]    key;
      logic [VERTEX_W-1:0] parent;
      logic [COST_W-1:0]   cost;
      logic [POS_W-1:0]    position;
      logic [COUNT_W-1:0]  count;
      logic                dropped;
   } node_rsp_type;

   typedef struct packed {
      logic         known;
      node_req_type rq;
      node_rsp_type rsp;
   } directed_row_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [FUNC_W-1:0]     req_tuser  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;

   // Shadow copy of the open list.
   logic [VERTEX_W-1:0] open_vertex [LIST_LEN];
   logic [KEY_W-1:0]    open_key    [LIST_LEN];
   logic [VERTEX_W-1:0] open_parent [LIST_LEN];
   logic [COST_W-1:0]   open_cost   [LIST_LEN];
   int                  open_fill = 0;

   node_rsp_type     expected_rsp [$];
   directed_row_type directed_table [DIR_N];

   int fail_count   = 0;
   int req_sent     = 0;
   int rsp_seen     = 0;
   int drop_count   = 0;
   int empty_pops   = 0;
   int find_hits    = 0;
   int peak_fill    = 0;
   int burst_left   = 0;
   int quiet_cycles = 0;

   sorted_node_priority_list #(
      .LEN     (LIST_LEN),
      .ID_BITS (VERTEX_W)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Open a slot at the given index, shifting toward the tail; lose the tail when full.
   function automatic logic place_entry(input int slot, input node_req_type rq);
      logic lost;
      int   last;
      int   k;
      lost = (open_fill >= LIST_LEN);
      last = lost ? LIST_LEN - 1 : open_fill;
      if (!lost) begin
         open_fill++;
      end
      for (k = last; k > slot; k--) begin
         open_vertex[k] = open_vertex[k-1];
         open_key[k]    = open_key[k-1];
         open_parent[k] = open_parent[k-1];
         open_cost[k]   = open_cost[k-1];
      end
      open_vertex[slot] = rq.vertex;
      open_key[slot]    = rq.key;
      open_parent[slot] = rq.parent;
      open_cost[slot]   = rq.cost;
      return lost;
   endfunction

   // Apply one request to the shadow list and return the response it must produce.
   function automatic node_rsp_type apply_request(input node_req_type rq);
      node_rsp_type r;
      int           slot;
      int           k;
      r = '0;
      case (rq.func)
         FUNC_INSERT_SORTED: begin
            // first stored key strictly greater wins, so equal keys queue behind
            slot = open_fill;
            for (k = open_fill - 1; k >= 0; k--) begin
               if (open_key[k] > rq.key) slot = k;
            end
            if (slot >= LIST_LEN) r.dropped = 1'b1;
            else r.dropped = place_entry(slot, rq);
         end
         FUNC_ADD_FIRST: begin
            r.dropped = place_entry(0, rq);
         end
         FUNC_ADD_END: begin
            if (open_fill >= LIST_LEN) r.dropped = 1'b1;
            else r.dropped = place_entry(open_fill, rq);
         end
         FUNC_REMOVE_FIRST: begin
            if (open_fill > 0) begin
               r.entry_valid = 1'b1;
               r.vertex      = open_vertex[0];
               r.key         = open_key[0];
               r.parent      = open_parent[0];
               r.cost        = open_cost[0];
               for (k = 0; k < open_fill - 1; k++) begin
                  open_vertex[k] = open_vertex[k+1];
                  open_key[k]    = open_key[k+1];
                  open_parent[k] = open_parent[k+1];
                  open_cost[k]   = open_cost[k+1];
               end
               open_fill--;
            end
         end
         FUNC_FIND: begin
            // scan downward so the lowest matching slot is kept
            for (k = open_fill - 1; k >= 0; k--) begin
               if (open_vertex[k] == rq.vertex) begin
                  r.entry_valid = 1'b1;
                  r.position    = POS_W'(k);
               end
            end
         end
         default: ;
      endcase
      r.count = COUNT_W'(open_fill);
      return r;
   endfunction

   function automatic node_req_type mk_req(input logic [FUNC_W-1:0] f, input int v,
                                           input logic [KEY_W-1:0] k, input int p,
                                           input logic [COST_W-1:0] c);
      return {f, VERTEX_W'(v), k, VERTEX_W'(p), c};
   endfunction

   function automatic directed_row_type known_row(input node_req_type rq,
                                                  input node_rsp_type rsp);
      return {1'b1, rq, rsp};
   endfunction

   function automatic directed_row_type step_row(input node_req_type rq);
      return {1'b0, rq, node_rsp_type'('0)};
   endfunction

   // Favor a few small ids so finds hit and duplicates occur; keep the extremes in play.
   function automatic logic [VERTEX_W-1:0] draw_id();
      case ($urandom_range(0, 3))
         0, 1:    return VERTEX_W'($urandom_range(0, 31));
         2:       return $urandom_range(0, 1) ? '1 : '0;
         default: return VERTEX_W'($urandom);
      endcase
   endfunction

   // Small words give equal keys, extremes hit both ends of the ordering.
   function automatic logic [31:0] draw_word();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 32'($urandom_range(0, 15));
         4:          return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
         default:    return 32'($urandom);
      endcase
   endfunction

   // Pick the next operation, steering the fill level toward the phase target.
   function automatic node_req_type draw_request(input int target);
      node_req_type rq;
      int           roll;
      int           ins_lim, first_lim, end_lim, rem_lim, find_lim;
      roll = $urandom_range(0, 99);
      if (open_fill < target) begin
         ins_lim = 50; first_lim = 65; end_lim = 80; rem_lim = 88; find_lim = 97;
      end else if (open_fill > target) begin
         ins_lim = 12; first_lim = 16; end_lim = 20; rem_lim = 75; find_lim = 97;
      end else begin
         ins_lim = 30; first_lim = 42; end_lim = 54; rem_lim = 74; find_lim = 96;
      end
      rq.vertex = draw_id();
      rq.key    = draw_word();
      rq.parent = draw_id();
      rq.cost   = draw_word();
      if (roll < ins_lim)        rq.func = FUNC_INSERT_SORTED;
      else if (roll < first_lim) rq.func = FUNC_ADD_FIRST;
      else if (roll < end_lim)   rq.func = FUNC_ADD_END;
      else if (roll < rem_lim)   rq.func = FUNC_REMOVE_FIRST;
      else if (roll < find_lim)  rq.func = FUNC_FIND;
      else rq.func = FUNC_SPARE_LO + FUNC_W'($urandom_range(0, 2));
      // mostly search for an id that is actually held
      if (rq.func == FUNC_FIND && open_fill > 0 && $urandom_range(0, 9) < 7) begin
         rq.vertex = open_vertex[$urandom_range(0, open_fill - 1)];
      end
      return rq;
   endfunction

   // Offer one request, pacing the sender in bursts; record its response once accepted.
   task automatic send_request(input node_req_type rq, input logic known,
                               input node_rsp_type want);
      node_rsp_type          predicted;
      logic [REQ_DATA_W-1:0] packed_req;
      int                    gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      packed_req = '0;
      packed_req[REQ_VERTEX_LSB +: VERTEX_W] = rq.vertex;
      packed_req[REQ_KEY_LSB    +: KEY_W]    = rq.key;
      packed_req[REQ_PARENT_LSB +: VERTEX_W] = rq.parent;
      packed_req[REQ_COST_LSB   +: COST_W]   = rq.cost;
      req_tdata  <= packed_req;
      req_tuser  <= rq.func;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predicted = apply_request(rq);
      expected_rsp.push_back(known ? want : predicted);
      req_sent++;
      if (predicted.dropped) drop_count++;
      if (rq.func == FUNC_REMOVE_FIRST && !predicted.entry_valid) empty_pops++;
      if (rq.func == FUNC_FIND && predicted.entry_valid) find_hits++;
      if (open_fill > peak_fill) peak_fill = open_fill;
   endtask

   // Stimulus: reset, directed table, phased random traffic, then drain and report.
   initial begin
      int target;
      int i;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      directed_table = '{
         // pop and search on an empty list
         known_row(mk_req(FUNC_REMOVE_FIRST, 0, 32'h0, 0, 32'h0), '0),
         known_row(mk_req(FUNC_FIND, 0, 32'h0, 0, 32'h0), '0),
         // all-ones entry in, then straight back out
         known_row(mk_req(FUNC_INSERT_SORTED, 1023, 32'hFFFF_FFFF, 1023, 32'hFFFF_FFFF),
                   {1'b0, 10'd0, 32'h0, 10'd0, 32'h0, 6'd0, 7'd1, 1'b0}),
         known_row(mk_req(FUNC_REMOVE_FIRST, 0, 32'h0, 0, 32'h0),
                   {1'b1, 10'd1023, 32'hFFFF_FFFF, 10'd1023, 32'hFFFF_FFFF,
                    6'd0, 7'd0, 1'b0}),
         known_row(mk_req(FUNC_INSERT_SORTED, 0, 32'h0, 0, 32'h0),
                   {1'b0, 10'd0, 32'h0, 10'd0, 32'h0, 6'd0, 7'd1, 1'b0}),
         // ordering, equal keys behind, maximum key to the tail
         step_row(mk_req(FUNC_INSERT_SORTED, 5, 32'd100, 3, 32'd7)),
         step_row(mk_req(FUNC_INSERT_SORTED, 6, 32'd100, 4, 32'd8)),
         step_row(mk_req(FUNC_INSERT_SORTED, 7, 32'd50, 5, 32'd9)),
         step_row(mk_req(FUNC_INSERT_SORTED, 10, 32'hFFFF_FFFF, 1023, 32'h0)),
         step_row(mk_req(FUNC_ADD_FIRST, 8, 32'hFFFF_FFFF, 1, 32'd1)),
         step_row(mk_req(FUNC_ADD_END, 9, 32'h0, 2, 32'd2)),
         step_row(mk_req(FUNC_INSERT_SORTED, 11, 32'h0, 0, 32'hFFFF_FFFF)),
         // hits in the middle and in the last slot, a miss, a hit on id zero
         step_row(mk_req(FUNC_FIND, 6, 32'h0, 0, 32'h0)),
         step_row(mk_req(FUNC_FIND, 9, 32'h0, 0, 32'h0)),
         step_row(mk_req(FUNC_FIND, 1023, 32'hFFFF_FFFF, 1023, 32'hFFFF_FFFF)),
         step_row(mk_req(FUNC_FIND, 0, 32'h0, 0, 32'h0)),
         // spare codes report the count only
         step_row(mk_req(FUNC_SPARE_LO, 1023, 32'hFFFF_FFFF, 1023, 32'hFFFF_FFFF)),
         step_row(mk_req(FUNC_SPARE_LO + 3'd1, 3, 32'd3, 3, 32'd3)),
         step_row(mk_req(FUNC_SPARE_HI, 0, 32'h0, 0, 32'h0)),
         step_row(mk_req(FUNC_REMOVE_FIRST, 0, 32'h0, 0, 32'h0)),
         step_row(mk_req(FUNC_REMOVE_FIRST, 0, 32'h0, 0, 32'h0)),
         step_row(mk_req(FUNC_ADD_END, 1023, 32'd5, 0, 32'hFFFF_FFFF)),
         step_row(mk_req(FUNC_FIND, 1023, 32'h0, 0, 32'h0))
      };

      foreach (directed_table[i]) begin
         send_request(directed_table[i].rq, directed_table[i].known, directed_table[i].rsp);
      end

      // phases: fill up, churn at full, drain to empty, then two random levels
      target = LIST_LEN;
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % PHASE_ITEMS == 0) begin
            case (i / PHASE_ITEMS)
               0, 1:    target = LIST_LEN;
               2:       target = 0;
               default: target = $urandom_range(0, LIST_LEN);
            endcase
         end
         send_request(draw_request(target), 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered: %0d requests (%0d directed), %0d responses, peak fill %0d of %0d",
               req_sent, DIR_N, rsp_seen, peak_fill, LIST_LEN);
      $display("covered: %0d full-list drops, %0d pops on empty, %0d find hits, %0d mismatches",
               drop_count, empty_pops, find_hits, fail_count);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Receiver: switch between stall patterns; hold off once for a long stretch to back up the list.
   initial begin
      int  mode;
      int  run_len;
      int  tick;
      bit  held_off;
      held_off = 1'b0;
      tick     = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      forever begin
         if (!held_off && rsp_seen >= HOLDOFF_AFTER) begin
            held_off = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
         end
         mode    = $urandom_range(0, 3);
         run_len = $urandom_range(4, 40);
         repeat (run_len) begin
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               2:       rsp_tready <= (tick % 4 == 0);
               default: rsp_tready <= (tick % 16 == 0);
            endcase
            tick++;
            @(posedge clock);
         end
      end
   end

   function automatic void check_field(input string name, input longint unsigned want,
                                       input longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // Compare each accepted response against the oldest pending expectation.
   always @(posedge clock) begin
      node_rsp_type got;
      node_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.entry_valid = rsp_tuser;
         got.vertex      = rsp_tdata[RSP_VERTEX_LSB +: VERTEX_W];
         got.key         = rsp_tdata[RSP_KEY_LSB    +: KEY_W];
         got.parent      = rsp_tdata[RSP_PARENT_LSB +: VERTEX_W];
         got.cost        = rsp_tdata[RSP_COST_LSB   +: COST_W];
         got.position    = rsp_tdata[RSP_POS_LSB    +: POS_W];
         got.count       = rsp_tdata[RSP_COUNT_LSB  +: COUNT_W];
         got.dropped     = rsp_tdata[RSP_DROP_LSB];
         rsp_seen++;
         if (expected_rsp.size() == 0) begin
            $error("response with no request pending: tdata %h tuser %b", rsp_tdata, rsp_tuser);
            fail_count++;
         end else begin
            want = expected_rsp.pop_front();
            check_field("entry_valid", want.entry_valid, got.entry_valid);
            check_field("out_vertex", want.vertex, got.vertex);
            check_field("out_key", want.key, got.key);
            check_field("out_parent", want.parent, got.parent);
            check_field("out_parent_cost", want.cost, got.cost);
            check_field("position", want.position, got.position);
            check_field("count", want.count, got.count);
            check_field("dropped", want.dropped, got.dropped);
         end
      end
   end

   // Watchdog: end the run when neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d responses outstanding",
                     quiet_cycles, expected_rsp.size());
            $display("status: fail");
            $finish;
         end
      end
   end

endmodule

@@ filelist.f @@
rtl/snpl_pkg.sv
rtl/snpl_cell.sv
rtl/sorted_node_priority_list.sv
verif/sorted_node_priority_list_tb.sv
